// ----- hdl/plir_pkg.sv -----
package plir_pkg;

  localparam int LIST_DEPTH  = 128;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;
  localparam int POS_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 8;
  localparam int ADDR_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_RM_RD,
    S_RM_TAKE,
    S_DN_RD,
    S_DN_WR,
    S_PK_RD,
    S_PK_TAKE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX_M1,
    RD_IDX_P1,
    RD_POS_M1,
    RD_CNT_M1
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_NEW
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POSM1,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load_in;
    logic    stat_load;
    logic    take;
    logic    we;
    logic    out_load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ok;
    logic             up_more;
    logic             dn_more;
  } dp_sts_t;

endpackage

// ----- hdl/plir_in_if.sv -----
interface plir_in_if;
  logic                                valid;
  logic                                ready;
  logic [plir_pkg::CMD_W-1:0]          cmd;
  logic [plir_pkg::POS_W-1:0]          position;
  logic signed [plir_pkg::DATA_W-1:0]  value_in;

  modport source (output valid, cmd, position, value_in, input ready);
  modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

// ----- hdl/plir_out_if.sv -----
interface plir_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [plir_pkg::DATA_W-1:0]     value_out;
  logic [plir_pkg::STATUS_W-1:0]          status;
  logic [plir_pkg::COUNT_OUT_W-1:0]       count_out;

  modport source (output valid, value_out, status, count_out, input ready);
  modport sink   (input valid, value_out, status, count_out, output ready);
endinterface

// ----- hdl/plir_ram.sv -----
module plir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/plir_dpath.sv -----
module plir_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [plir_pkg::CMD_W-1:0]         cmd,
  input  logic [plir_pkg::POS_W-1:0]         position,
  input  logic signed [plir_pkg::DATA_W-1:0] value_in,
  input  plir_pkg::dp_ctl_t                  ctl,
  output plir_pkg::dp_sts_t                  sts,
  output logic signed [plir_pkg::DATA_W-1:0] value_out,
  output logic [plir_pkg::STATUS_W-1:0]      status,
  output logic [plir_pkg::COUNT_OUT_W-1:0]   count_out
);
  import plir_pkg::*;

  logic [CMD_W-1:0]         cmd_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] taken_r;
  logic [STATUS_W-1:0]      stat_r;
  logic [STATUS_W-1:0]      chk_status;
  logic signed [DATA_W-1:0] value_out_r;
  logic [STATUS_W-1:0]      status_r;
  logic [COUNT_OUT_W-1:0]   count_out_r;

  logic [CMP_W-1:0] pos_w, cnt_w, idx_w;
  logic [CMP_W-1:0] pos_m1, idx_m1, idx_p1, cnt_m1;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign pos_w  = CMP_W'(pos_r);
  assign cnt_w  = CMP_W'(count_r);
  assign idx_w  = CMP_W'(idx_r);
  assign pos_m1 = pos_w - CMP_W'(1);
  assign idx_m1 = idx_w - CMP_W'(1);
  assign idx_p1 = idx_w + CMP_W'(1);
  assign cnt_m1 = cnt_w - CMP_W'(1);

  always_comb begin
    chk_status = ST_OK;
    case (cmd_r)
      CMD_INSERT: begin
        if (cnt_w >= CMP_W'(LIST_DEPTH)) begin
          chk_status = ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          chk_status = ST_BADPOS;
        end
      end
      CMD_REMOVE: begin
        if (cnt_w == '0) begin
          chk_status = ST_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          chk_status = ST_BADPOS;
        end
      end
      CMD_PEEK: begin
        if (cnt_w == '0) begin
          chk_status = ST_EMPTY;
        end
      end
      default: chk_status = ST_BADPOS;
    endcase
  end

  assign sts.cmd     = cmd_r;
  assign sts.ok      = (chk_status == ST_OK);
  // insert moves entry i-1 to i while i >= pos
  assign sts.up_more = (idx_w >= pos_w);
  // remove moves entry i+1 to i while i+1 < count
  assign sts.dn_more = (idx_p1 < cnt_w);

  always_comb begin
    case (ctl.rd_sel)
      RD_IDX_M1: ram_raddr = ADDR_W'(idx_m1);
      RD_IDX_P1: ram_raddr = ADDR_W'(idx_p1);
      RD_POS_M1: ram_raddr = ADDR_W'(pos_m1);
      RD_CNT_M1: ram_raddr = ADDR_W'(cnt_m1);
      default:   ram_raddr = ADDR_W'(idx_m1);
    endcase
  end

  always_comb begin
    case (ctl.wr_sel)
      WR_SHIFT: begin
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = ram_rdata;
      end
      WR_NEW: begin
        ram_waddr = ADDR_W'(pos_m1);
        ram_wdata = val_r;
      end
      default: begin
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = ram_rdata;
      end
    endcase
  end

  assign ram_we = ctl.we;

  always_comb begin
    case (ctl.idx_op)
      IDX_HOLD:  idx_nxt = idx_r;
      IDX_CNT:   idx_nxt = count_r;
      IDX_POSM1: idx_nxt = CNT_W'(pos_m1);
      IDX_DEC:   idx_nxt = idx_r - CNT_W'(1);
      IDX_INC:   idx_nxt = idx_r + CNT_W'(1);
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (ctl.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_INC:  count_nxt = count_r + CNT_W'(1);
      CNT_DEC:  count_nxt = count_r - CNT_W'(1);
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.load_in) begin
      cmd_r   <= cmd;
      pos_r   <= position;
      val_r   <= value_in;
      taken_r <= '0;
    end else if (ctl.take) begin
      taken_r <= ram_rdata;
    end
    if (ctl.stat_load) begin
      stat_r <= chk_status;
    end
    if (ctl.out_load) begin
      value_out_r <= taken_r;
      status_r    <= stat_r;
      count_out_r <= COUNT_OUT_W'(count_r);
    end
  end

  assign value_out = value_out_r;
  assign status    = status_r;
  assign count_out = count_out_r;

  plir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- hdl/plir_ctrl.sv -----
module plir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  plir_pkg::dp_sts_t sts,
  output plir_pkg::dp_ctl_t ctl
);
  import plir_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl.load_in   = 1'b0;
    ctl.stat_load = 1'b0;
    ctl.take      = 1'b0;
    ctl.we        = 1'b0;
    ctl.out_load  = 1'b0;
    ctl.rd_sel    = RD_IDX_M1;
    ctl.wr_sel    = WR_SHIFT;
    ctl.idx_op    = IDX_HOLD;
    ctl.cnt_op    = CNT_HOLD;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.stat_load = 1'b1;
        if (!sts.ok) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.cmd)
            CMD_INSERT: begin
              ctl.idx_op = IDX_CNT;
              state_nxt  = S_UP_RD;
            end
            CMD_REMOVE: state_nxt = S_RM_RD;
            CMD_PEEK:   state_nxt = S_PK_RD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_UP_RD: begin
        ctl.rd_sel = RD_IDX_M1;
        if (sts.up_more) begin
          state_nxt = S_UP_WR;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_UP_WR: begin
        ctl.we     = 1'b1;
        ctl.wr_sel = WR_SHIFT;
        ctl.idx_op = IDX_DEC;
        state_nxt  = S_UP_RD;
      end
      S_INS_WR: begin
        ctl.we     = 1'b1;
        ctl.wr_sel = WR_NEW;
        ctl.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_RM_RD: begin
        ctl.rd_sel = RD_POS_M1;
        state_nxt  = S_RM_TAKE;
      end
      S_RM_TAKE: begin
        ctl.take   = 1'b1;
        ctl.idx_op = IDX_POSM1;
        state_nxt  = S_DN_RD;
      end
      S_DN_RD: begin
        ctl.rd_sel = RD_IDX_P1;
        if (sts.dn_more) begin
          state_nxt = S_DN_WR;
        end else begin
          ctl.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_DN_WR: begin
        ctl.we     = 1'b1;
        ctl.wr_sel = WR_SHIFT;
        ctl.idx_op = IDX_INC;
        state_nxt  = S_DN_RD;
      end
      S_PK_RD: begin
        ctl.rd_sel = RD_CNT_M1;
        state_nxt  = S_PK_TAKE;
      end
      S_PK_TAKE: begin
        ctl.take  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/positional_list_insert_remove_unit.sv -----
// channel  dir  handshake          word
// in_chan  in   valid/ready        cmd, position, value_in
// out_chan out  valid/ready        value_out, status, count_out
//
// one item at a time; refused items pass idle, eval and done; a peek adds read and take
// insert adds a last read and the new write, remove adds read, take and a last read
// each moved entry costs a read then a write on the single list ram port pair
// reset clears the count and control; list contents are not cleared
// a new word is taken while the previous result still waits in the output register
module positional_list_insert_remove_unit (
  input logic         clk,
  input logic         rst_n,
  plir_in_if.sink     in_chan,
  plir_out_if.source  out_chan
);
  import plir_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  plir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  plir_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (in_chan.cmd),
    .position  (in_chan.position),
    .value_in  (in_chan.value_in),
    .ctl       (ctl),
    .sts       (sts),
    .value_out (out_chan.value_out),
    .status    (out_chan.status),
    .count_out (out_chan.count_out)
  );

endmodule

// ----- dv/tb.sv -----
module tb;
  import plir_pkg::*;

  // cmd code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   count;
  } list_word_t;

  logic clk;
  logic rst_n;

  plir_in_if  in_chan();
  plir_out_if out_chan();

  positional_list_insert_remove_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic signed [DATA_W-1:0] list_model[$];
  list_word_t pending_words[$];
  int fail_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  // updates the list copy and returns the word the block should answer with
  function automatic list_word_t apply_list_op(logic [CMD_W-1:0] cmd,
                                               logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] val);
    list_word_t w;
    int p;
    int n;
    p = int'(pos);
    n = list_model.size();
    w.value = '0;
    w.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (n >= LIST_DEPTH) begin
          w.status = ST_FULL;
        end else if (p == 0 || p > n + 1) begin
          w.status = ST_BADPOS;
        end else begin
          list_model.insert(p - 1, val);
        end
      end
      CMD_REMOVE: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else if (p == 0 || p > n) begin
          w.status = ST_BADPOS;
        end else begin
          w.value = list_model[p - 1];
          list_model.delete(p - 1);
        end
      end
      CMD_PEEK: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.value = list_model[n - 1];
        end
      end
      default: w.status = ST_BADPOS;
    endcase
    w.count = COUNT_OUT_W'(list_model.size());
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.cmd      <= cmd;
    in_chan.position <= pos;
    in_chan.value_in <= val;
    in_chan.valid    <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_words.push_back(apply_list_op(cmd, pos, val));
    @(negedge clk);
  endtask

  task automatic send_random_insert();
    send_word(CMD_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)), $urandom());
  endtask

  task automatic send_random_remove();
    send_word(CMD_REMOVE, POS_W'($urandom_range(1, list_model.size())), $urandom());
  endtask

  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    wait (pending_words.size() == 0);
    @(negedge clk);
  endtask

  task automatic test_edge_cases();
    no_idle = 1'b0;
    send_word(CMD_PEEK, 8'd0, 32'sd0);
    send_word(CMD_REMOVE, 8'd1, 32'sd0);
    send_word(CMD_REMOVE, POS_MAX, 32'sd0);
    send_word(CMD_UNUSED, 8'd1, VAL_MAX);
    send_word(CMD_INSERT, 8'd0, 32'sd5);
    send_word(CMD_INSERT, 8'd2, 32'sd5);
    send_word(CMD_INSERT, POS_MAX, 32'sd5);
    send_word(CMD_INSERT, 8'd1, VAL_MIN);
    send_word(CMD_INSERT, 8'd2, VAL_MAX);
    send_word(CMD_INSERT, 8'd1, -32'sd1);
    send_word(CMD_INSERT, 8'd2, 32'sd0);
    send_word(CMD_PEEK, POS_MAX, 32'sd7);
    send_word(CMD_REMOVE, 8'd0, 32'sd0);
    send_word(CMD_REMOVE, 8'd5, 32'sd0);
    send_word(CMD_REMOVE, POS_MAX, 32'sd0);
    send_word(CMD_UNUSED, POS_MAX, VAL_MIN);
    send_word(CMD_REMOVE, 8'd2, 32'sd0);
    send_word(CMD_REMOVE, 8'd3, 32'sd0);
    send_word(CMD_REMOVE, 8'd1, 32'sd0);
    send_word(CMD_REMOVE, 8'd1, 32'sd0);
    send_word(CMD_PEEK, 8'd1, 32'sd0);
  endtask

  task automatic test_full_list();
    while (list_model.size() < LIST_DEPTH) begin
      no_idle = (list_model.size() % 32) >= 24;
      send_random_insert();
    end
    no_idle = 1'b0;
    // a full list refuses inserts without looking at the position
    send_word(CMD_INSERT, 8'd1, $urandom());
    send_word(CMD_INSERT, 8'd0, $urandom());
    send_word(CMD_INSERT, POS_W'(LIST_DEPTH + 1), $urandom());
    send_word(CMD_INSERT, POS_MAX, $urandom());
    send_word(CMD_PEEK, 8'd0, 32'sd0);
    send_word(CMD_REMOVE, POS_W'(LIST_DEPTH + 1), 32'sd0);
    send_word(CMD_REMOVE, POS_W'(LIST_DEPTH), 32'sd0);
    send_word(CMD_INSERT, POS_W'(LIST_DEPTH), $urandom());
    send_word(CMD_REMOVE, 8'd1, 32'sd0);
    send_word(CMD_INSERT, 8'd1, $urandom());
    while (list_model.size() > 0) begin
      no_idle = (list_model.size() % 32) < 6;
      send_random_remove();
    end
  endtask

  task automatic test_random_walk(int n_items);
    int sel;
    int insert_pct;
    bit filling;
    filling = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 180 == 0) filling = !filling;
      if (i == n_items / 2) hold_until_drained();
      insert_pct = filling ? 75 : 15;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // noise: any cmd, any position
        send_word(CMD_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 255)), $urandom());
      end else if (sel < 8 + insert_pct) begin
        send_random_insert();
      end else if (sel < 95) begin
        send_random_remove();
      end else begin
        send_word(CMD_PEEK, POS_W'($urandom_range(0, 255)), $urandom());
      end
    end
  endtask

  // result side stall, drawn per word
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    list_word_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: value_out %0d status %0d count_out %0d",
               out_chan.value_out, out_chan.status, out_chan.count_out);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_chan.value_out !== want.value) begin
          $error("value_out mismatch: expected %0d, got %0d", want.value, out_chan.value_out);
          fail_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.count_out !== want.count) begin
          $error("count_out mismatch: expected %0d, got %0d", want.count, out_chan.count_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_PEEK;
    in_chan.position = '0;
    in_chan.value_in = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_full_list();
    test_random_walk(960);
    in_chan.valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
